>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the waveform burst generator.
// Define NO_ASSERTIONS to compile every check out of the design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rstn, prop)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

>>> design/dwb_pkg.sv
// ----------------------------------------------------------------------------
// dwb_pkg
// Types and fixed constants of the waveform burst generator.
// ----------------------------------------------------------------------------
package dwb_pkg;

    localparam int KIND_W    = 2;
    localparam int PHASE_W   = 32;
    localparam int AMP_W     = 15;
    localparam int SAMPLE_W  = 16;
    localparam int MAG_W     = 32;
    localparam int TAB_W     = 15;
    localparam int PROD_W    = AMP_W + MAG_W;

    // Stream widths (tdata rounded up to whole bytes)
    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = KIND_W;
    localparam int M_TDATA_W = SAMPLE_W;

    // Waveform codes
    localparam logic [KIND_W-1:0] KIND_SINE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SQUARE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SAW    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TRI    = 2'd3;

    localparam logic [PHASE_W-1:0] HALF_TURN = 32'h8000_0000;

    // One burst request as taken from the input stream
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [PHASE_W-1:0] step;
        logic [PHASE_W-1:0] start;
        logic [AMP_W-1:0]   amp;
    } dwb_req_t;

    // One sample to be synthesised
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [PHASE_W-1:0] phase;
        logic [AMP_W-1:0]   amp;
        logic               last;
    } dwb_smp_t;

endpackage

>>> design/dwb_burst_seq.sv
// ----------------------------------------------------------------------------
// dwb_burst_seq
// Phase accumulator and frame counter: turns one request into a burst of
// FRAMES sample phases, one per advancing cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dwb_burst_seq
    import dwb_pkg::*;
#(
    parameter int FRAMES = 64
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     req_valid,
    input  dwb_req_t req,
    output logic     req_ready,
    input  logic     adv,
    output logic     smp_valid,
    output dwb_smp_t smp
);

    localparam int CNT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    logic               busy_reg,  busy_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [PHASE_W-1:0] step_reg,  step_next;
    logic [KIND_W-1:0]  kind_reg,  kind_next;
    logic [AMP_W-1:0]   amp_reg,   amp_next;

    logic is_last;
    logic issue;
    logic accept;

    assign is_last   = (count_reg == CNT_W'(FRAMES - 1));
    assign issue     = busy_reg && adv;
    // a new request may land on the cycle the last sample leaves
    assign req_ready = !busy_reg || (issue && is_last);
    assign accept    = req_valid && req_ready;

    // Next-state logic
    always_comb begin
        busy_next  = busy_reg;
        count_next = count_reg;
        phase_next = phase_reg;
        step_next  = step_reg;
        kind_next  = kind_reg;
        amp_next   = amp_reg;
        if (accept) begin
            busy_next  = 1'b1;
            count_next = '0;
            phase_next = req.start;
            step_next  = req.step;
            kind_next  = req.kind;
            amp_next   = req.amp;
        end else if (issue) begin
            if (is_last) begin
                busy_next = 1'b0;
            end else begin
                count_next = count_reg + 1'b1;
                phase_next = phase_reg + step_reg;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
        end
    end

    // Request payload and phase
    always_ff @(posedge aclk) begin
        phase_reg <= phase_next;
        step_reg  <= step_next;
        kind_reg  <= kind_next;
        amp_reg   <= amp_next;
    end

    assign smp_valid  = busy_reg;
    assign smp.kind   = kind_reg;
    assign smp.phase  = phase_reg;
    assign smp.amp    = amp_reg;
    assign smp.last   = is_last;

    `ASSERT_NEXT(a_accept_starts_burst, aclk, aresetn, accept, busy_reg && count_reg == '0)
    `ASSERT_NEXT(a_last_ends_burst, aclk, aresetn, issue && is_last && !accept, !busy_reg)
    `ASSERT_ALWAYS(a_count_in_range, aclk, aresetn, !busy_reg || count_reg <= CNT_W'(FRAMES - 1))

endmodule

>>> design/dwb_sine_rom.sv
// ----------------------------------------------------------------------------
// dwb_sine_rom
// Quarter-wave sine table, DEPTH+1 entries of 15 bits, built at elaboration
// from a Q2.30 Taylor series. Registered read.
// ----------------------------------------------------------------------------
module dwb_sine_rom
    import dwb_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [$clog2(DEPTH+1)-1:0]   addr,
    output logic [TAB_W-1:0]             data_reg
);

    // round(32767 * sin(pi/2 * k / DEPTH)) through x^15/15!
    function automatic logic [TAB_W-1:0] sine_entry(input int k);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        x    = (64'd1686629713 * 64'(k)) / 64'(DEPTH);
        term = x;
        sum  = x;
        for (int n = 1; n <= 7; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            case (n)
                1:       term = term / 6;
                2:       term = term / 20;
                3:       term = term / 42;
                4:       term = term / 72;
                5:       term = term / 110;
                6:       term = term / 156;
                default: term = term / 210;
            endcase
            if (n[0]) begin
                sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
                sum = sum + term;
            end
        end
        v = (sum * 64'd32767 + 64'd536870912) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[TAB_W-1:0];
    endfunction

    logic [TAB_W-1:0] rom [0:DEPTH];

    for (genvar k = 0; k <= DEPTH; k++) begin : g_rom
        assign rom[k] = sine_entry(k);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= rom[addr];
        end
    end

endmodule

>>> design/dwb_wave_path.sv
// ----------------------------------------------------------------------------
// dwb_wave_path
// Four-stage waveform datapath: phase decode, table read, amplitude multiply,
// rounding and sign. The whole pipe stalls when the output is held.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dwb_wave_path
    import dwb_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       smp_valid,
    input  dwb_smp_t                   smp,
    output logic                       adv,
    input  logic                       m_tready,
    output logic                       m_tvalid,
    output logic signed [SAMPLE_W-1:0] sample,
    output logic                       last
);

    localparam int IW = $clog2(4 * SINE_TABLE_DEPTH);
    localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PW = PHASE_W + IW + 1;

    // ---- stage 1: phase decode ----
    logic [PW-1:0]      sine_prod;
    logic [PHASE_W-1:0] f;
    logic [PHASE_W-1:0] fold_dist;
    logic [PHASE_W:0]   tri_u;
    logic               tri_ge;
    logic [MAG_W-1:0]   s1_mag;
    logic               s1_neg;

    logic               p1_valid_reg;
    logic [KIND_W-1:0]  p1_kind_reg;
    logic [AMP_W-1:0]   p1_amp_reg;
    logic               p1_last_reg;
    logic [IW-1:0]      p1_idx_reg;
    logic [MAG_W-1:0]   p1_mag_reg;
    logic               p1_neg_reg;

    assign f         = smp.phase;
    assign sine_prod = PW'(f) * PW'(4 * SINE_TABLE_DEPTH);
    assign fold_dist = f[PHASE_W-1] ? (f - HALF_TURN) : (HALF_TURN - f);
    assign tri_u     = {fold_dist, 1'b0};
    assign tri_ge    = (tri_u >= {1'b0, HALF_TURN});

    always_comb begin
        s1_mag = '0;
        s1_neg = 1'b0;
        case (smp.kind)
            KIND_SQUARE: begin
                s1_neg = f[PHASE_W-1];
            end
            KIND_SAW: begin
                s1_mag = fold_dist;
                s1_neg = !f[PHASE_W-1];
            end
            KIND_TRI: begin
                s1_mag = tri_ge ? MAG_W'(tri_u - {1'b0, HALF_TURN})
                                : MAG_W'({1'b0, HALF_TURN} - tri_u);
                s1_neg = !tri_ge;
            end
            default: begin
                s1_mag = '0;
                s1_neg = 1'b0;
            end
        endcase
    end

    // ---- stage 2: quadrant fold and table read ----
    logic [1:0]         quad;
    logic [IW-1:0]      quad_base;
    logic [IW-1:0]      rem;
    logic [AW-1:0]      rom_addr;
    logic [TAB_W-1:0]   rom_data;

    logic               p2_valid_reg;
    logic [KIND_W-1:0]  p2_kind_reg;
    logic [AMP_W-1:0]   p2_amp_reg;
    logic               p2_last_reg;
    logic [MAG_W-1:0]   p2_mag_reg;
    logic               p2_neg_reg;

    always_comb begin
        if (p1_idx_reg >= IW'(3 * SINE_TABLE_DEPTH)) begin
            quad = 2'd3;
        end else if (p1_idx_reg >= IW'(2 * SINE_TABLE_DEPTH)) begin
            quad = 2'd2;
        end else if (p1_idx_reg >= IW'(SINE_TABLE_DEPTH)) begin
            quad = 2'd1;
        end else begin
            quad = 2'd0;
        end
        case (quad)
            2'd1:    quad_base = IW'(SINE_TABLE_DEPTH);
            2'd2:    quad_base = IW'(2 * SINE_TABLE_DEPTH);
            2'd3:    quad_base = IW'(3 * SINE_TABLE_DEPTH);
            default: quad_base = '0;
        endcase
        rem      = p1_idx_reg - quad_base;
        rom_addr = quad[0] ? AW'(IW'(SINE_TABLE_DEPTH) - rem) : AW'(rem);
    end

    dwb_sine_rom #(
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
        .aclk     (aclk),
        .en       (adv),
        .addr     (rom_addr),
        .data_reg (rom_data)
    );

    // ---- stage 3: amplitude multiply ----
    logic [MAG_W-1:0]   mul_op;
    logic               p3_valid_reg;
    logic [KIND_W-1:0]  p3_kind_reg;
    logic [AMP_W-1:0]   p3_amp_reg;
    logic               p3_last_reg;
    logic               p3_neg_reg;
    logic [PROD_W-1:0]  p3_prod_reg;

    assign mul_op = (p2_kind_reg == KIND_SINE) ? MAG_W'(rom_data) : p2_mag_reg;

    // ---- stage 4: rounding, sign, output register ----
    logic [PROD_W-1:0]   rnd_tab;
    logic [PROD_W-1:0]   rnd_q31;
    logic [SAMPLE_W-1:0] mag16;
    logic [SAMPLE_W-1:0] signed16;

    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic                       out_last_reg;

    assign rnd_tab = p3_prod_reg + PROD_W'(1 << 14);
    assign rnd_q31 = p3_prod_reg + PROD_W'(1 << 30);

    always_comb begin
        case (p3_kind_reg)
            KIND_SINE:   mag16 = rnd_tab[15 +: SAMPLE_W];
            KIND_SQUARE: mag16 = {1'b0, p3_amp_reg};
            default:     mag16 = rnd_q31[31 +: SAMPLE_W];
        endcase
        signed16 = p3_neg_reg ? (~mag16 + 1'b1) : mag16;
    end

    // Whole pipe moves unless a finished sample is held
    assign adv = !out_valid_reg || m_tready;

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            p1_valid_reg  <= smp_valid;
            p2_valid_reg  <= p1_valid_reg;
            p3_valid_reg  <= p2_valid_reg;
            out_valid_reg <= p3_valid_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_kind_reg    <= smp.kind;
            p1_amp_reg     <= smp.amp;
            p1_last_reg    <= smp.last;
            p1_idx_reg     <= sine_prod[PHASE_W +: IW];
            p1_mag_reg     <= s1_mag;
            p1_neg_reg     <= s1_neg;

            p2_kind_reg    <= p1_kind_reg;
            p2_amp_reg     <= p1_amp_reg;
            p2_last_reg    <= p1_last_reg;
            p2_mag_reg     <= p1_mag_reg;
            p2_neg_reg     <= (p1_kind_reg == KIND_SINE) ? quad[1] : p1_neg_reg;

            p3_kind_reg    <= p2_kind_reg;
            p3_amp_reg     <= p2_amp_reg;
            p3_last_reg    <= p2_last_reg;
            p3_neg_reg     <= p2_neg_reg;
            p3_prod_reg    <= PROD_W'(p2_amp_reg) * PROD_W'(mul_op);

            out_sample_reg <= signed16;
            out_last_reg   <= p3_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign sample   = out_sample_reg;
    assign last     = out_last_reg;

    `ASSERT_ALWAYS(a_rom_addr_range, aclk, aresetn, !p1_valid_reg || rom_addr <= AW'(SINE_TABLE_DEPTH))
    `ASSERT_ALWAYS(a_square_mag, aclk, aresetn, !p3_valid_reg || p3_kind_reg != KIND_SQUARE || mag16 == {1'b0, p3_amp_reg})

endmodule

>>> design/dds_waveform_burst_generator_core.sv
// ----------------------------------------------------------------------------
// dds_waveform_burst_generator_core
// Burst waveform synthesiser: each request yields FRAMES samples of a sine,
// square, sawtooth or triangle wave from a wrapping 32-bit phase accumulator.
// ----------------------------------------------------------------------------
// Sample path: a taken request loads the burst sequencer, and each sample then
//   moves through the p1, p2, p3 and output registers. Throughput: one sample
//   per cycle unless the output is held, from the single phase accumulator.
// Back-to-back requests: the next one is taken as the last sample issues.
// Reset: aresetn synchronous, active low; clears all valid and busy state.
module dds_waveform_burst_generator_core
    import dwb_pkg::*;
#(
    parameter int FRAMES           = 64,
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [31:0] phase_step, [63:32] start_phase, [78:64] amplitude, [79] zero
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // [1:0] kind
    input  logic [S_TUSER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [15:0] sample
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tlast
);

    dwb_req_t                   req;
    dwb_smp_t                   smp;
    logic                       smp_valid;
    logic                       adv;
    logic signed [SAMPLE_W-1:0] sample;

    // Unpack the request
    assign req.kind  = s_tuser[KIND_W-1:0];
    assign req.step  = s_tdata[0 +: PHASE_W];
    assign req.start = s_tdata[PHASE_W +: PHASE_W];
    assign req.amp   = s_tdata[2*PHASE_W +: AMP_W];

    dwb_burst_seq #(
        .FRAMES (FRAMES)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req       (req),
        .req_ready (s_tready),
        .adv       (adv),
        .smp_valid (smp_valid),
        .smp       (smp)
    );

    dwb_wave_path #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_wave (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .smp_valid (smp_valid),
        .smp       (smp),
        .adv       (adv),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .sample    (sample),
        .last      (m_tlast)
    );

    assign m_tdata = M_TDATA_W'(sample);

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the waveform burst generator sample by sample. Each request taken
// from the input stream is expanded into its 64-sample burst by a bit-exact
// model held in a scoreboard. Every sample leaving the core is compared with
// the oldest expected one. Traffic mixes directed corner cases with random
// bursts, random input gaps and output back-pressure, a long output hold-off and a
// full drain.
// ----------------------------------------------------------------------------
module testbench;
    import dwb_pkg::*;

    localparam int FRAMES         = 64;
    localparam int SINE_DEPTH     = 256;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 20;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned HALF_T      = 64'h8000_0000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } burst_sample_t;

    // Burst model and queue of samples still owed by the core
    class dds_scoreboard;
        bit [15:0]     quarter_sine [SINE_DEPTH+1];
        burst_sample_t owed_q [$];
        int unsigned   errors;

        function new();
            errors = 0;
            for (int k = 0; k <= SINE_DEPTH; k++)
                quarter_sine[k] = sine_entry(k);
        endfunction

        // Q2.30 Taylor series through x^15/15!, rounded half up and clamped
        function bit [15:0] sine_entry(int k);
            longint unsigned x;
            longint unsigned term;
            longint unsigned acc;
            longint unsigned v;
            x    = HALF_PI_Q30 * longint'(k) / longint'(SINE_DEPTH);
            term = x;
            acc  = x;
            for (int n = 1; n <= 7; n++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / longint'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    acc = (acc >= term) ? acc - term : 64'd0;
                else
                    acc = acc + term;
            end
            v = (acc * 64'd32767 + 64'd536870912) >> 30;
            if (v > 64'd32767)
                v = 64'd32767;
            return v[15:0];
        endfunction

        // Q1.31 magnitude times amplitude, rounded half away from zero
        function int scale_q31(longint unsigned amp, longint unsigned mag, bit neg);
            longint unsigned m;
            m = (amp * mag + 64'd1073741824) >> 31;
            return neg ? -int'(m) : int'(m);
        endfunction

        function logic signed [SAMPLE_W-1:0] wave_value(logic [KIND_W-1:0] kind,
                                                        longint unsigned f,
                                                        longint unsigned amp);
            longint unsigned idx;
            longint unsigned quad;
            longint unsigned r;
            longint unsigned t;
            longint unsigned d;
            longint unsigned u;
            int              s;
            case (kind)
                KIND_SINE: begin
                    idx  = (f * longint'(4 * SINE_DEPTH)) >> 32;
                    quad = (idx / SINE_DEPTH) & 3;
                    r    = idx % SINE_DEPTH;
                    t    = quad[0] ? quarter_sine[SINE_DEPTH - r] : quarter_sine[r];
                    s    = int'((amp * t + 64'd16384) >> 15);
                    if (quad >= 2)
                        s = -s;
                end
                KIND_SQUARE: begin
                    s = (f >= HALF_T) ? -int'(amp) : int'(amp);
                end
                KIND_SAW: begin
                    if (f >= HALF_T)
                        s = scale_q31(amp, f - HALF_T, 1'b0);
                    else
                        s = scale_q31(amp, HALF_T - f, 1'b1);
                end
                default: begin
                    d = (f >= HALF_T) ? f - HALF_T : HALF_T - f;
                    u = 2 * d;
                    if (u >= HALF_T)
                        s = scale_q31(amp, u - HALF_T, 1'b0);
                    else
                        s = scale_q31(amp, HALF_T - u, 1'b1);
                end
            endcase
            return s[SAMPLE_W-1:0];
        endfunction

        // Expand an accepted request into its burst of samples
        function void note_request(logic [KIND_W-1:0] kind, logic [PHASE_W-1:0] step,
                                   logic [PHASE_W-1:0] start, logic [AMP_W-1:0] amp);
            logic [PHASE_W-1:0] phase;
            burst_sample_t      e;
            phase = start;
            for (int i = 0; i < FRAMES; i++) begin
                e.sample = wave_value(kind, longint'(phase), longint'(amp));
                e.last   = (i == FRAMES - 1);
                owed_q.push_back(e);
                phase = phase + step;
            end
        endfunction

        function void check_sample(logic [SAMPLE_W-1:0] sample, logic last);
            burst_sample_t e;
            if (owed_q.size() == 0) begin
                $error("unexpected sample %0d (last %0d)", $signed(sample), last);
                errors++;
                return;
            end
            e = owed_q.pop_front();
            if (sample !== e.sample) begin
                $error("sample mismatch: expected %0d, got %0d", e.sample, $signed(sample));
                errors++;
            end
            if (last !== e.last) begin
                $error("last mismatch: expected %0d, got %0d", e.last, last);
                errors++;
            end
        endfunction

        function int outstanding();
            return owed_q.size();
        endfunction
    endclass

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic [S_TUSER_W-1:0]  s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;

    dds_scoreboard sb = new();
    bit            idle_on      = 1'b1;
    bit            hold_pending = 1'b0;
    int            stall_left   = 0;
    int            quiet_cycles = 0;

    always #4 aclk = ~aclk;

    dds_waveform_burst_generator_core #(
        .FRAMES           (FRAMES),
        .SINE_TABLE_DEPTH (SINE_DEPTH)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Handshake monitors on both streams
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_request(s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[78:64]);
        if (aresetn && m_tvalid && m_tready)
            sb.check_sample(m_tdata, m_tlast);
    end

    // Output back-pressure: random short stalls, or one long hold-off on request
    always @(posedge aclk) begin
        if (aresetn) begin
            if (hold_pending) begin
                hold_pending = 1'b0;
                stall_left   = HOLD_CYCLES;
            end else if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 7);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on handshake activity
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $error("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Offer one burst request and hold it until taken
    task automatic send_request(logic [KIND_W-1:0] kind, logic [PHASE_W-1:0] step,
                                logic [PHASE_W-1:0] start, logic [AMP_W-1:0] amp);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {1'b0, amp, start, step};
        do @(posedge aclk); while (!s_tready);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        while (sb.outstanding() != 0)
            @(posedge aclk);
    endtask

    function automatic logic [PHASE_W-1:0] pick_step();
        case ($urandom_range(0, 5))
            0:       return $urandom();
            1:       return $urandom_range(0, 32'h0400_0000);
            2:       return 32'h0400_0000;
            3:       return 32'd0;
            4:       return 32'hFFFF_FFFF - $urandom_range(0, 32'h0100_0000);
            default: return $urandom_range(0, 32'h0010_0000);
        endcase
    endfunction

    function automatic logic [PHASE_W-1:0] pick_start();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return HALF_TURN;
            3:       return 32'h4000_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [AMP_W-1:0] pick_amp();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 15'd1;
            default: return AMP_W'($urandom());
        endcase
    endfunction

    task automatic send_random(int count);
        logic [KIND_W-1:0] kind;
        for (int i = 0; i < count; i++) begin
            kind = KIND_W'($urandom_range(KIND_SINE, KIND_TRI));
            send_request(kind, pick_step(), pick_start(), pick_amp());
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: full turns per kind, extremes, zero step, reverse step
        send_request(KIND_SINE,   32'h0400_0000, 32'h0000_0000, 15'h7FFF);
        send_request(KIND_SINE,   32'h0100_0000, 32'hC000_0000, 15'h7FFF);
        send_request(KIND_SINE,   32'h0123_4567, 32'h0000_0000, 15'd1);
        send_request(KIND_SINE,   32'h0400_0000, 32'h2000_0000, 15'd0);
        send_request(KIND_SINE,   32'hFFFF_FFFF, 32'h0000_0001, 15'd12345);
        send_request(KIND_SQUARE, 32'h0400_0000, 32'h0000_0000, 15'h7FFF);
        send_request(KIND_SQUARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 15'd0);
        send_request(KIND_SQUARE, 32'h0000_0001, 32'h7FFF_FFE0, 15'h7FFF);
        send_request(KIND_SAW,    32'h0400_0000, 32'h0000_0000, 15'h7FFF);
        send_request(KIND_SAW,    32'h8000_0000, 32'h8000_0000, 15'h7FFF);
        send_request(KIND_SAW,    32'h0000_0001, 32'h7FFF_FFE0, 15'd3);
        send_request(KIND_TRI,    32'h0400_0000, 32'h0000_0000, 15'h7FFF);
        send_request(KIND_TRI,    32'h4000_0000, 32'h4000_0000, 15'h7FFF);
        send_request(KIND_TRI,    32'h0000_0001, 32'h7FFF_FFE0, 15'h7FFF);
        send_request(KIND_SINE,   32'h0000_0000, 32'h4000_0000, 15'h7FFF);
        send_request(KIND_SQUARE, 32'h0000_0000, HALF_TURN,     15'h7FFF);
        send_request(KIND_SAW,    32'h0000_0000, 32'hFFFF_FFFF, 15'h7FFF);
        send_request(KIND_TRI,    32'h0000_0000, 32'h0000_0000, 15'h7FFF);
        send_request(KIND_TRI,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 15'h5555);
        send_request(KIND_SAW,    32'hFFFF_FFFF, 32'h0000_0000, 15'h2AAA);

        send_random(200);

        // Long output hold-off with requests offered back to back
        idle_on      = 1'b0;
        hold_pending = 1'b1;
        send_random(12);
        s_tvalid <= 1'b0;
        wait_drained();
        idle_on = 1'b1;
        @(posedge aclk);

        send_random(170);

        // Closing stretch at full rate on both sides
        idle_on = 1'b0;
        send_random(80);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/dwb_pkg.sv
design/dwb_burst_seq.sv
design/dwb_sine_rom.sv
design/dwb_wave_path.sv
design/dds_waveform_burst_generator_core.sv
tb/testbench.sv
